FILE: hw/rtl/ukf_pkg.sv
package ukf_pkg;

   localparam int KNOWN_DEPTH   = 64;
   localparam int PENDING_DEPTH = 16;
   localparam int KEY_BYTES     = 8;
   localparam int KEY_W         = 8 * KEY_BYTES;
   localparam int CMD_W         = 2;
   localparam int MAXP_W        = 5;
   localparam int SLOT_W        = 5;
   localparam int QUEUE_DEPTH   = 2;

   localparam int KNOWN_AW   = (KNOWN_DEPTH > 1) ? $clog2(KNOWN_DEPTH) : 1;
   localparam int PEND_AW    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int KNOWN_CW   = $clog2(KNOWN_DEPTH + 1);
   localparam int PEND_CW    = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W      = (KNOWN_CW > PEND_CW) ? KNOWN_CW : PEND_CW;
   localparam int QUEUE_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MAXP_W-1:0] NEW_KEY_CAP_RESET = MAXP_W'(16);

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic              is_summary;
      logic [KEY_W-1:0]  callsign;
      logic [SLOT_W-1:0] slot_or_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
   } work_type;

   function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic             live;
      r    = '0;
      live = 1'b1;
      for (int i = 0; i < KEY_BYTES; i++) begin
         live = live & (k[8*i +: 8] != 8'd0);
         r[8*i +: 8] = live ? k[8*i +: 8] : 8'd0;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/ukf_front.sv
module ukf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ukf_pkg::req_type  req_data,
   output logic              push,
   output ukf_pkg::work_type push_data,
   input  logic              full
);

   logic              frt_vld_ff, frt_vld_in;
   ukf_pkg::work_type frt_ff, frt_in;
   logic              accept;
   logic              keep;
   logic [ukf_pkg::KEY_W-1:0] nkey;

   assign push      = frt_vld_ff && !full;
   assign push_data = frt_ff;
   assign req_ready = !frt_vld_ff || push;
   assign accept    = req_valid && req_ready;
   assign nkey      = ukf_pkg::norm_key(req_data.key);

   always_comb begin
      keep       = 1'b0;
      frt_in.key = nkey;
      frt_in.op  = ukf_pkg::OP_LOAD;
      case (req_data.cmd)
         ukf_pkg::CMD_LOAD: begin
            keep      = 1'b1;
            frt_in.op = ukf_pkg::OP_LOAD;
         end
         ukf_pkg::CMD_QUERY: begin
            keep      = (nkey[7:0] != 8'd0);
            frt_in.op = ukf_pkg::OP_QUERY;
         end
         ukf_pkg::CMD_END: begin
            keep      = 1'b1;
            frt_in.op = ukf_pkg::OP_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      frt_vld_in = frt_vld_ff && !push;
      if (accept) begin
         frt_vld_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frt_vld_ff <= 1'b0;
      end else begin
         frt_vld_ff <= frt_vld_in;
      end
      if (accept) begin
         frt_ff <= frt_in;
      end
   end

endmodule

FILE: hw/rtl/ukf_queue.sv
module ukf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ukf_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output ukf_pkg::work_type pop_data,
   output logic              empty
);

   localparam int Aw    = ukf_pkg::QUEUE_AW;
   localparam int Cw    = ukf_pkg::QUEUE_CW;
   localparam int Depth = ukf_pkg::QUEUE_DEPTH;

   ukf_pkg::work_type entry_ff [Depth];
   logic [Aw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Aw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Cw-1:0] count_ff, count_in;

   assign full     = (count_ff == Cw'(Depth));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Aw'(Depth - 1)) ? '0 : wr_ptr_ff + Aw'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Aw'(Depth - 1)) ? '0 : rd_ptr_ff + Aw'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Cw'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Cw'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Cw'(Depth))
      else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/ukf_back.sv
module ukf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ukf_pkg::MAXP_W-1:0]     new_key_cap,
   input  logic                           empty,
   input  ukf_pkg::work_type              pop_data,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ukf_pkg::rsp_type               rsp_data
);

   localparam int KnownAw = ukf_pkg::KNOWN_AW;
   localparam int PendAw  = ukf_pkg::PEND_AW;
   localparam int KnownCw = ukf_pkg::KNOWN_CW;
   localparam int PendCw  = ukf_pkg::PEND_CW;
   localparam int IdxW    = ukf_pkg::IDX_W;
   localparam int SlotW   = ukf_pkg::SLOT_W;
   localparam int KeyW    = ukf_pkg::KEY_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_KNOWN = 3'd1;
   localparam logic [2:0] S_PEND  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;

   logic [KeyW-1:0] known_mem [ukf_pkg::KNOWN_DEPTH];
   logic [KeyW-1:0] pend_mem  [ukf_pkg::PENDING_DEPTH];
   logic [KeyW-1:0] known_rd_ff, pend_rd_ff;

   logic [2:0]         state_ff, state_in;
   logic [IdxW-1:0]    idx_ff, idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [KeyW-1:0]    cur_key_ff, cur_key_in;
   logic [KnownCw-1:0] known_count_ff, known_count_in;
   logic [PendCw-1:0]  pend_count_ff, pend_count_in;
   ukf_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ukf_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic known_we, pend_we, issue, hit, out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      cur_key_in     = cur_key_ff;
      known_count_in = known_count_ff;
      pend_count_in  = pend_count_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      pop            = 1'b0;
      known_we       = 1'b0;
      pend_we        = 1'b0;
      issue          = 1'b0;
      hit            = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               case (pop_data.op)
                  ukf_pkg::OP_LOAD: begin
                     if (known_count_ff < KnownCw'(ukf_pkg::KNOWN_DEPTH)) begin
                        known_we       = 1'b1;
                        known_count_in = known_count_ff + KnownCw'(1);
                     end
                  end
                  ukf_pkg::OP_QUERY: begin
                     cur_key_in = pop_data.key;
                     idx_in     = '0;
                     if (pend_count_ff < new_key_cap &&
                         pend_count_ff < PendCw'(ukf_pkg::PENDING_DEPTH)) begin
                        state_in = S_KNOWN;
                     end
                  end
                  ukf_pkg::OP_END: begin
                     res_in.is_summary    = 1'b1;
                     res_in.callsign      = '0;
                     res_in.slot_or_count = SlotW'(pend_count_ff);
                     known_count_in       = '0;
                     pend_count_in        = '0;
                     state_in             = S_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_KNOWN: begin
            issue     = idx_ff < IdxW'(known_count_ff);
            hit       = rd_vld_ff && (known_rd_ff == cur_key_ff);
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + IdxW'(1);
            end
            if (hit) begin
               state_in = S_IDLE;
            end else if (!issue) begin
               state_in  = S_PEND;
               idx_in    = '0;
               rd_vld_in = 1'b0;
            end
         end
         S_PEND: begin
            issue     = idx_ff < IdxW'(pend_count_ff);
            hit       = rd_vld_ff && (pend_rd_ff == cur_key_ff);
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + IdxW'(1);
            end
            if (hit) begin
               state_in = S_IDLE;
            end else if (!issue) begin
               pend_we              = 1'b1;
               res_in.is_summary    = 1'b0;
               res_in.callsign      = cur_key_ff;
               res_in.slot_or_count = SlotW'(pend_count_ff);
               pend_count_in        = pend_count_ff + PendCw'(1);
               state_in             = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rd_vld_ff      <= 1'b0;
         known_count_ff <= '0;
         pend_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_vld_ff      <= rd_vld_in;
         known_count_ff <= known_count_in;
         pend_count_ff  <= pend_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      cur_key_ff  <= cur_key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (known_we) begin
         known_mem[known_count_ff[KnownAw-1:0]] <= pop_data.key;
      end
      known_rd_ff <= known_mem[idx_ff[KnownAw-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_count_ff[PendAw-1:0]] <= cur_key_ff;
      end
      pend_rd_ff <= pend_mem[idx_ff[PendAw-1:0]];
   end

   a_known_bound: assert property (@(posedge clock) disable iff (reset)
      known_count_ff <= KnownCw'(ukf_pkg::KNOWN_DEPTH))
      else $error("known count beyond depth");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_count_ff <= PendCw'(ukf_pkg::PENDING_DEPTH))
      else $error("pending count beyond depth");

   a_pend_grow_emits: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && (pend_count_ff == $past(pend_count_ff) + PendCw'(1))
      |-> state_ff == S_EMIT && !res_ff.is_summary)
      else $error("pending count grew without a new key result");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE && !empty)
      else $error("work taken while busy");

endmodule

FILE: hw/rtl/uncached_key_filter_top.sv
// Key filter: emits query keys that are neither known nor already emitted.
// req channel (req_valid/req_ready/req_data): one transaction per command.
//   cmd 0 loads a known key, cmd 1 queries a key, cmd 2 ends the batch.
// rsp channel (rsp_valid/rsp_ready/rsp_data): one transaction per new key
//   (callsign and slot) and one per end of batch (is_summary set, count).
// csr channel (csr_valid/csr_ready/csr_data): writes the new-key cap per
//   batch; always ready. Write it only while no command is in flight.
// Keys are cut at their first zero byte before storing and comparing.
// A load passes the front register and the queue before it is stored; an end
//   also passes the result register before rsp_valid rises.
// A query walks the known store then the pending store one entry per cycle
//   through a registered memory read, and stops at the first match.
//   A query is dropped without a walk once the pending count reaches the cap.
// Items are worked one at a time; a front register and a two-entry queue
//   take up to three further commands while one is being worked.
// When rsp_ready is low the result holds in the output register; the back
//   stalls, then the queue fills, then req_ready drops.
// Reset empties both stores, the queue and the output, and sets the cap to 16.
module uncached_key_filter_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ukf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ukf_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ukf_pkg::MAXP_W-1:0]    csr_data
);

   logic [ukf_pkg::MAXP_W-1:0] new_key_cap_ff;
   logic              push, full, pop, empty;
   ukf_pkg::work_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         new_key_cap_ff <= ukf_pkg::NEW_KEY_CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         new_key_cap_ff <= csr_data;
      end
   end

   ukf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   ukf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   ukf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .new_key_cap (new_key_cap_ff),
      .empty       (empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
